// File: sv/lbit_pkg.sv
// ---------------------------------------------------------------------------
// lbit_pkg
// Shared types and constants for the line versus box intersection test.
// ---------------------------------------------------------------------------
package lbit_pkg;

   localparam int CoordWidth = 32;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = CoordWidth + DiffWidth;
   localparam int SumWidth   = ProdWidth + 1;
   localparam int FractionBits = 16;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;
   typedef logic signed [ProdWidth-1:0]  prod_type;
   typedef logic signed [SumWidth-1:0]   sum_type;

   typedef enum logic [2:0] {
      CSR_DIMENSION = 3'd0,
      CSR_POINT_X   = 3'd1,
      CSR_POINT_Y   = 3'd2,
      CSR_POINT_Z   = 3'd3,
      CSR_DIR_X     = 3'd4,
      CSR_DIR_Y     = 3'd5,
      CSR_DIR_Z     = 3'd6
   } csr_index_type;

   localparam logic [1:0] Dim2d = 2'd2;
   localparam coord_type  DirXReset = coord_type'(64'sd1 <<< FractionBits);

   // sign of a sum: 2'b01 positive, 2'b11 negative, 2'b00 zero
   function automatic logic [1:0] sgn(input sum_type v);
      logic [1:0] r;
      begin
         if (v == '0) r = 2'b00;
         else if (v[SumWidth-1]) r = 2'b11;
         else r = 2'b01;
         return r;
      end
   endfunction

   // true when product of signs a*b <= 0
   function automatic logic opp(input logic [1:0] a, input logic [1:0] b);
      return (a == 2'b00) || (b == 2'b00) || (a[1] != b[1]);
   endfunction

endpackage

// File: sv/line_box_intersection_test.sv
// ---------------------------------------------------------------------------
// line_box_intersection_test
// Tests an infinite line held in registers against one axis-aligned box per
// request; Q16.16 coordinates, exact sign tests on wide products.
// ---------------------------------------------------------------------------
// A request is taken in every cycle (busy is always low) and its hit result
// appears on rsp_valid/rsp_hit after the pipeline, in request order; the
// result is shown for exactly one cycle and cannot be held off. The pipeline
// stages are subtract, multiply, add, and compare and combine.
// Write the registers only while no request is in flight.
module line_box_intersection_test (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  lbit_pkg::coord_type        req_box_low_x,
   input  lbit_pkg::coord_type        req_box_low_y,
   input  lbit_pkg::coord_type        req_box_low_z,
   input  lbit_pkg::coord_type        req_box_high_x,
   input  lbit_pkg::coord_type        req_box_high_y,
   input  lbit_pkg::coord_type        req_box_high_z,
   output logic                       rsp_valid,
   output logic                       rsp_hit,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_index,
   input  logic [31:0]                csr_data
);
   import lbit_pkg::*;

   logic [1:0] dim_ff;
   coord_type  px_ff, py_ff, pz_ff, dx_ff, dy_ff, dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= 2'd3;
         px_ff <= '0; py_ff <= '0; pz_ff <= '0;
         dx_ff <= DirXReset; dy_ff <= '0; dz_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIMENSION: dim_ff <= csr_data[1:0];
            CSR_POINT_X:   px_ff <= csr_data;
            CSR_POINT_Y:   py_ff <= csr_data;
            CSR_POINT_Z:   pz_ff <= csr_data;
            CSR_DIR_X:     dx_ff <= csr_data;
            CSR_DIR_Y:     dy_ff <= csr_data;
            CSR_DIR_Z:     dz_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // axis choice from configuration (the user must keep it static while requests are in flight; not enforced here)
   logic [DiffWidth-1:0] ax, ay, az;
   logic [1:0] p_sel;
   logic is2d, dzero;
   coord_type dp, da, db, pp, pa, pb;
   always_comb begin
      ax = dx_ff[CoordWidth-1] ? DiffWidth'(-diff_type'(dx_ff)) : DiffWidth'(dx_ff);
      ay = dy_ff[CoordWidth-1] ? DiffWidth'(-diff_type'(dy_ff)) : DiffWidth'(dy_ff);
      az = dz_ff[CoordWidth-1] ? DiffWidth'(-diff_type'(dz_ff)) : DiffWidth'(dz_ff);
      is2d = (dim_ff == Dim2d);
      if (is2d) p_sel = 2'd2;
      else if (ax > ay && ax > az) p_sel = 2'd0;
      else if (ay > az) p_sel = 2'd1;
      else p_sel = 2'd2;
      case (p_sel)
         2'd0: begin dp = dx_ff; pp = px_ff; da = dy_ff; pa = py_ff; db = dz_ff; pb = pz_ff; end
         2'd1: begin dp = dy_ff; pp = py_ff; da = dx_ff; pa = px_ff; db = dz_ff; pb = pz_ff; end
         default: begin
            dp = dz_ff; pp = pz_ff; da = dx_ff; pa = px_ff; db = dy_ff; pb = py_ff;
         end
      endcase
      if (is2d) begin
         da = dx_ff; pa = px_ff; db = dy_ff; pb = py_ff;
      end
      dzero = is2d ? (dx_ff == '0 && dy_ff == '0) : (dp == '0);
   end

   // box coordinates on axes p, a, b
   coord_type lp, hp, la, ha, lb, hb;
   always_comb begin
      case (p_sel)
         2'd0: begin
            lp = req_box_low_x; hp = req_box_high_x; la = req_box_low_y;
            ha = req_box_high_y; lb = req_box_low_z; hb = req_box_high_z;
         end
         2'd1: begin
            lp = req_box_low_y; hp = req_box_high_y; la = req_box_low_x;
            ha = req_box_high_x; lb = req_box_low_z; hb = req_box_high_z;
         end
         default: begin
            lp = req_box_low_z; hp = req_box_high_z; la = req_box_low_x;
            ha = req_box_high_x; lb = req_box_low_y; hb = req_box_high_y;
         end
      endcase
      if (is2d) begin
         la = req_box_low_x; ha = req_box_high_x;
         lb = req_box_low_y; hb = req_box_high_y;
      end
   end

   // stage 1: differences
   logic s1_v_ff;
   diff_type lpp_ff, hpp_ff, pla_ff, pha_ff, plb_ff, phb_ff;
   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else s1_v_ff <= start;
      lpp_ff <= diff_type'(lp) - diff_type'(pp);
      hpp_ff <= diff_type'(hp) - diff_type'(pp);
      pla_ff <= diff_type'(pa) - diff_type'(la);
      pha_ff <= diff_type'(pa) - diff_type'(ha);
      plb_ff <= diff_type'(pb) - diff_type'(lb);
      phb_ff <= diff_type'(pb) - diff_type'(hb);
   end

   // stage 2: products
   logic s2_v_ff;
   prod_type m_pla_ff, m_pha_ff, m_plb_ff, m_phb_ff;
   prod_type m_alp_ff, m_ahp_ff, m_blp_ff, m_bhp_ff;
   prod_type c_bla_ff, c_bha_ff, c_alb_ff, c_ahb_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else s2_v_ff <= s1_v_ff;
      m_pla_ff <= prod_type'(pla_ff) * prod_type'(dp);
      m_pha_ff <= prod_type'(pha_ff) * prod_type'(dp);
      m_plb_ff <= prod_type'(plb_ff) * prod_type'(dp);
      m_phb_ff <= prod_type'(phb_ff) * prod_type'(dp);
      m_alp_ff <= prod_type'(da) * prod_type'(lpp_ff);
      m_ahp_ff <= prod_type'(da) * prod_type'(hpp_ff);
      m_blp_ff <= prod_type'(db) * prod_type'(lpp_ff);
      m_bhp_ff <= prod_type'(db) * prod_type'(hpp_ff);
      c_bla_ff <= prod_type'(db) * prod_type'(pla_ff);
      c_bha_ff <= prod_type'(db) * prod_type'(pha_ff);
      c_alb_ff <= prod_type'(da) * prod_type'(plb_ff);
      c_ahb_ff <= prod_type'(da) * prod_type'(phb_ff);
   end

   // stage 3: sums
   logic s3_v_ff;
   sum_type t_ff [12];
   always_ff @(posedge clock) begin
      if (reset) s3_v_ff <= 1'b0;
      else s3_v_ff <= s2_v_ff;
      t_ff[0]  <= sum_type'(m_pla_ff) + sum_type'(m_alp_ff);
      t_ff[1]  <= sum_type'(m_pla_ff) + sum_type'(m_ahp_ff);
      t_ff[2]  <= sum_type'(m_pha_ff) + sum_type'(m_alp_ff);
      t_ff[3]  <= sum_type'(m_pha_ff) + sum_type'(m_ahp_ff);
      t_ff[4]  <= sum_type'(m_plb_ff) + sum_type'(m_blp_ff);
      t_ff[5]  <= sum_type'(m_plb_ff) + sum_type'(m_bhp_ff);
      t_ff[6]  <= sum_type'(m_phb_ff) + sum_type'(m_blp_ff);
      t_ff[7]  <= sum_type'(m_phb_ff) + sum_type'(m_bhp_ff);
      t_ff[8]  <= sum_type'(c_bla_ff) - sum_type'(c_alb_ff);
      t_ff[9]  <= sum_type'(c_bha_ff) - sum_type'(c_ahb_ff);
      t_ff[10] <= sum_type'(c_bla_ff) - sum_type'(c_ahb_ff);
      t_ff[11] <= sum_type'(c_bha_ff) - sum_type'(c_alb_ff);
   end

   // stage 4: sign tests and combine
   logic [1:0] sg [12];
   logic neg_dir, rej, corner, hit_in;
   always_comb begin
      for (int i = 0; i < 12; i++) sg[i] = sgn(t_ff[i]);
      neg_dir = dp[CoordWidth-1];
      rej = 1'b0;
      if (!is2d) begin
         for (int k = 0; k < 2; k++) begin
            // low side: both cut points below low edge
            if (sg[4*k][1] != sg[4*k+1][1] || sg[4*k] == 2'b00 || sg[4*k+1] == 2'b00) ;
            else if (sg[4*k][1] == neg_dir) ;
            else rej = 1'b1;
            if (sg[4*k+2] == 2'b00 || sg[4*k+3] == 2'b00 || sg[4*k+2][1] != sg[4*k+3][1]) ;
            else if (sg[4*k+2][1] != neg_dir) ;
            else rej = 1'b1;
         end
      end
      corner = opp(sg[8], sg[9]) || opp(sg[8], sg[10]) || opp(sg[8], sg[11]);
      hit_in = !dzero && !rej && corner;
   end

   logic rsp_valid_ff, rsp_hit_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= s3_v_ff;
      rsp_hit_ff <= hit_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##4 rsp_valid) else $error("response missing");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(s3_v_ff)) else $error("spurious response");
   a_zero_dir: assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && dzero) |=> !rsp_hit) else $error("hit with zero direction");

endmodule
